// ===== src/stable_counting_sort_by_key_macros.svh =====
// Assertion macros for the stable counting sort block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef STABLE_COUNTING_SORT_BY_KEY_MACROS_SVH
`define STABLE_COUNTING_SORT_BY_KEY_MACROS_SVH

// Same-cycle implication.
`define SCSK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scsk assertion failed");

// Next-cycle implication.
`define SCSK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scsk assertion failed");

`endif

// ===== src/scsk_pkg.sv =====
// Shared constants and types for the stable counting sort block.
// Used by the controller, the datapath and the top level; depends on nothing.
package scsk_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int MAX_BUCKETS = 16;

    localparam int KEY_W   = 4;
    localparam int CFG_W   = 5;
    localparam int FIELD_W = 6;
    localparam int IDX_W   = $clog2(MAX_ITEMS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int BKT_W   = $clog2(MAX_BUCKETS);

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(8);

    typedef struct packed {
        logic load;
        logic pfx;
        logic scat;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic empty_run;
        logic pfx_last;
        logic scat_done;
        logic emit_done;
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [BKT_W-1:0] bucket;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] rank;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ===== src/scsk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/scsk_ctrl.sv =====
// Sequencing controller: load, prefix pass, scatter pass, emit pass.
// Depends on scsk_pkg for the command and status structs.
module scsk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last,
    input  scsk_pkg::t_status i_status,
    output scsk_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    typedef enum logic [1:0] {
        IDLE,
        PREFIX,
        SCATTER,
        EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_last && !i_status.empty_run) begin
                    n_state = PREFIX;
                end
            end
            PREFIX: begin
                o_cmd.pfx = 1'b1;
                if (i_status.pfx_last) begin
                    n_state = SCATTER;
                end
            end
            SCATTER: begin
                o_cmd.scat = 1'b1;
                if (i_status.scat_done) begin
                    n_state = EMIT;
                end
            end
            EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state     = IDLE;
                end
            end
            default: begin
                n_state = IDLE;
            end
        endcase
        n_busy = (n_state != IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== src/scsk_dp.sv =====
// Datapath: bucket counters, prefix offsets, key store and sorted slot store.
// Depends on scsk_pkg and scsk_ram; driven by commands from scsk_ctrl.
module scsk_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scsk_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [scsk_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_last,
    input  scsk_pkg::t_cmd                i_cmd,
    output scsk_pkg::t_status             o_status,
    output logic                          o_strobe,
    output logic [scsk_pkg::FIELD_W-1:0]  o_item_index,
    output logic [scsk_pkg::KEY_W-1:0]    o_bucket,
    output logic [scsk_pkg::FIELD_W-1:0]  o_bucket_start,
    output logic [scsk_pkg::FIELD_W-1:0]  o_rank_in_bucket,
    output logic                          o_error,
    output logic                          o_last_out
);

    localparam int IDX_W = scsk_pkg::IDX_W;
    localparam int CNT_W = scsk_pkg::CNT_W;
    localparam int BKT_W = scsk_pkg::BKT_W;

    logic [scsk_pkg::CFG_W-1:0] r_bcount;
    logic [CNT_W-1:0]           r_loaded;
    logic                       r_dropped;
    logic [CNT_W-1:0]           r_cnt   [scsk_pkg::MAX_BUCKETS];
    logic [CNT_W-1:0]           r_start [scsk_pkg::MAX_BUCKETS];
    logic [BKT_W-1:0]           r_b;
    logic [CNT_W-1:0]           r_sum;
    logic [CNT_W-1:0]           r_si;
    logic                       r_sv;
    logic [IDX_W-1:0]           r_sidx;
    logic [CNT_W-1:0]           r_ei;
    logic                       r_ev;
    logic [IDX_W-1:0]           r_eidx;

    logic                         r_ostb;
    logic [scsk_pkg::FIELD_W-1:0] r_oidx;
    logic [scsk_pkg::KEY_W-1:0]   r_obkt;
    logic [scsk_pkg::FIELD_W-1:0] r_ostart;
    logic [scsk_pkg::FIELD_W-1:0] r_orank;
    logic                         r_oerr;
    logic                         r_olast;

    logic                       key_ok;
    logic [BKT_W-1:0]           key_b;
    logic [scsk_pkg::KEY_W-1:0] key_rd;
    logic [BKT_W-1:0]           cnt_addr;
    logic [CNT_W-1:0]           cnt_rd;
    logic [CNT_W-1:0]           start_rd;
    logic                       scat_issue;
    logic                       emit_issue;
    logic                       emit_final;
    scsk_pkg::t_slot            slot_wr;
    scsk_pkg::t_slot            slot_rd;

    assign key_b  = BKT_W'(i_key);
    assign key_ok = ({1'b0, i_key} < r_bcount)
                 && (int'(i_key) < scsk_pkg::MAX_BUCKETS)
                 && (r_loaded != CNT_W'(scsk_pkg::MAX_ITEMS));

    // The counter array is read at one place per cycle, chosen by the phase.
    always_comb begin
        if (i_cmd.pfx) begin
            cnt_addr = r_b;
        end else if (i_cmd.scat) begin
            cnt_addr = BKT_W'(key_rd);
        end else begin
            cnt_addr = key_b;
        end
        cnt_rd   = r_cnt[cnt_addr];
        start_rd = r_start[cnt_addr];
    end

    assign scat_issue = i_cmd.scat && (r_si != r_loaded);
    assign emit_issue = i_cmd.emit && (r_ei != r_loaded);
    assign emit_final = (r_eidx == IDX_W'(r_loaded - CNT_W'(1)));

    // Each item lands at its bucket's next free slot; rank is the distance from the start.
    assign slot_wr.idx    = r_sidx;
    assign slot_wr.bucket = BKT_W'(key_rd);
    assign slot_wr.start  = IDX_W'(start_rd);
    assign slot_wr.rank   = IDX_W'(cnt_rd - start_rd);

    scsk_ram #(
        .WIDTH (scsk_pkg::KEY_W),
        .DEPTH (scsk_pkg::MAX_ITEMS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && key_ok),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wdata (i_key),
        .i_raddr (r_si[IDX_W-1:0]),
        .o_rdata (key_rd)
    );

    scsk_ram #(
        .WIDTH (scsk_pkg::SLOT_W),
        .DEPTH (scsk_pkg::MAX_ITEMS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (r_sv),
        .i_waddr (cnt_rd[IDX_W-1:0]),
        .i_wdata (slot_wr),
        .i_raddr (r_ei[IDX_W-1:0]),
        .o_rdata (slot_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount  <= scsk_pkg::BUCKET_COUNT_RESET;
            r_loaded  <= '0;
            r_dropped <= 1'b0;
            r_cnt     <= '{default: '0};
            r_b       <= '0;
            r_sum     <= '0;
            r_si      <= '0;
            r_sv      <= 1'b0;
            r_ei      <= '0;
            r_ev      <= 1'b0;
            r_ostb    <= 1'b0;
        end else begin
            r_ostb <= 1'b0;
            r_sv   <= scat_issue;
            r_ev   <= emit_issue;
            if (i_cfg_we) begin
                r_bcount <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (key_ok) begin
                    r_cnt[cnt_addr] <= cnt_rd + CNT_W'(1);
                    r_loaded        <= r_loaded + CNT_W'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
                // A run that ends with nothing stored answers at once.
                if (i_last && r_loaded == '0 && !key_ok) begin
                    r_ostb    <= 1'b1;
                    r_dropped <= 1'b0;
                end
            end
            if (i_cmd.pfx) begin
                r_cnt[cnt_addr] <= r_sum;
                r_sum           <= r_sum + cnt_rd;
                r_b             <= r_b + BKT_W'(1);
            end
            if (scat_issue) begin
                r_si <= r_si + CNT_W'(1);
            end
            if (i_cmd.scat && r_sv) begin
                r_cnt[cnt_addr] <= cnt_rd + CNT_W'(1);
            end
            if (emit_issue) begin
                r_ei <= r_ei + CNT_W'(1);
            end
            if (i_cmd.emit && r_ev) begin
                r_ostb <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_loaded  <= '0;
                r_dropped <= 1'b0;
                r_cnt     <= '{default: '0};
                r_b       <= '0;
                r_sum     <= '0;
                r_si      <= '0;
                r_ei      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pfx) begin
            r_start[cnt_addr] <= r_sum;
        end
        if (scat_issue) begin
            r_sidx <= r_si[IDX_W-1:0];
        end
        if (emit_issue) begin
            r_eidx <= r_ei[IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_oidx   <= '0;
            r_obkt   <= '0;
            r_ostart <= '0;
            r_orank  <= '0;
            r_oerr   <= 1'b1;
            r_olast  <= 1'b1;
        end else if (r_ev) begin
            r_oidx   <= scsk_pkg::FIELD_W'(slot_rd.idx);
            r_obkt   <= scsk_pkg::KEY_W'(slot_rd.bucket);
            r_ostart <= scsk_pkg::FIELD_W'(slot_rd.start);
            r_orank  <= scsk_pkg::FIELD_W'(slot_rd.rank);
            r_oerr   <= emit_final && r_dropped;
            r_olast  <= emit_final;
        end
    end

    assign o_status.empty_run = (r_loaded == '0) && !key_ok;
    assign o_status.pfx_last  = (r_b == BKT_W'(scsk_pkg::MAX_BUCKETS - 1));
    assign o_status.scat_done = (r_si == r_loaded) && !r_sv;
    assign o_status.emit_done = (r_ei == r_loaded) && !r_ev;

    assign o_strobe         = r_ostb;
    assign o_item_index     = r_oidx;
    assign o_bucket         = r_obkt;
    assign o_bucket_start   = r_ostart;
    assign o_rank_in_bucket = r_orank;
    assign o_error          = r_oerr;
    assign o_last_out       = r_olast;

endmodule

// ===== src/stable_counting_sort_by_key.sv =====
// Stable counting sort by key. Keys are taken one beat per cycle while busy is low; the
// beat with i_last set starts the sort. The block then stays busy through a prefix pass
// over the bucket counters, a scatter pass that reads the key store one slot a cycle, and
// an emit pass that reads the sorted slot store one slot a cycle. Each result is shown on
// strobe for exactly one cycle and the receiver cannot stall it. A run with no stored
// item answers in the cycle after its last beat.
module stable_counting_sort_by_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [scsk_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [scsk_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_last,
    output logic                          strobe,
    output logic [scsk_pkg::FIELD_W-1:0]  o_item_index,
    output logic [scsk_pkg::KEY_W-1:0]    o_bucket,
    output logic [scsk_pkg::FIELD_W-1:0]  o_bucket_start,
    output logic [scsk_pkg::FIELD_W-1:0]  o_rank_in_bucket,
    output logic                          o_error,
    output logic                          o_last_out
);

    `include "stable_counting_sort_by_key_macros.svh"

    scsk_pkg::t_cmd    cmd;
    scsk_pkg::t_status status;

    scsk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    scsk_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_key            (i_key),
        .i_last           (i_last),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_strobe         (strobe),
        .o_item_index     (o_item_index),
        .o_bucket         (o_bucket),
        .o_bucket_start   (o_bucket_start),
        .o_rank_in_bucket (o_rank_in_bucket),
        .o_error          (o_error),
        .o_last_out       (o_last_out)
    );

    // Only the final beat of a run may carry the error flag.
    `SCSK_ASSERT_IMP(a_err_on_final, strobe && o_error, o_last_out)
    // Results other than the final one come out only while the block is busy.
    `SCSK_ASSERT_IMP(a_mid_while_busy, strobe && !o_last_out, busy)
    // A closing beat either starts the sort or answers an empty run at once.
    `SCSK_ASSERT_NXT(a_last_reacts, start && !busy && i_last, busy || strobe)

endmodule

// ===== dv/tb_stable_counting_sort_by_key.sv =====
// Self-checking testbench for stable_counting_sort_by_key: directed rows, then random batches.
// Predicts the sorted stream on its own and compares every strobed result beat.
// Depends on scsk_pkg and the stable_counting_sort_by_key top level only.
module tb_stable_counting_sort_by_key;

    localparam int FIELD_W     = scsk_pkg::FIELD_W;
    localparam int KEY_W       = scsk_pkg::KEY_W;
    localparam int CFG_W       = scsk_pkg::CFG_W;
    localparam int MAX_ITEMS   = scsk_pkg::MAX_ITEMS;
    localparam int MAX_BUCKETS = scsk_pkg::MAX_BUCKETS;

    localparam int DRAIN_CYCLES   = 2 * MAX_ITEMS + 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 7;

    typedef struct packed {
        logic [FIELD_W-1:0] item_index;
        logic [KEY_W-1:0]   bucket;
        logic [FIELD_W-1:0] bucket_start;
        logic [FIELD_W-1:0] rank;
        logic               error;
        logic               last_out;
    } t_sorted_slot;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [KEY_W-1:0] key;
        logic           last;
        logic [CFG_W-1:0] cfg;
        logic           typed;
        t_sorted_slot   want;
    } t_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic [KEY_W-1:0]   i_key       = '0;
    logic               i_last      = 1'b0;
    logic               strobe;
    logic [FIELD_W-1:0] o_item_index;
    logic [KEY_W-1:0]   o_bucket;
    logic [FIELD_W-1:0] o_bucket_start;
    logic [FIELD_W-1:0] o_rank_in_bucket;
    logic               o_error;
    logic               o_last_out;

    // Travels with the beat so the monitor knows whether its result was typed in by hand.
    logic               tag_typed = 1'b0;
    t_sorted_slot       tag_want  = '0;

    // Predictor state.
    logic [KEY_W-1:0]   slot_key [MAX_ITEMS];
    logic [6:0]         bucket_tally [MAX_BUCKETS];
    int unsigned        n_loaded;
    logic               dropped;
    logic [CFG_W-1:0]   bucket_limit;

    t_sorted_slot       sorted_q [$];
    t_sorted_slot       got_want;
    t_row               directed_rows [$];
    int unsigned        mismatches = 0;
    int unsigned        quiet_cycles = 0;
    int                 cur_limit = 8;

    int ph_cfg   [N_PHASES] = '{16, 16, 5, 31, 1, 12, 0};
    int ph_idle  [N_PHASES] = '{0, 46, 17, 46, 0, 17, 46};
    int ph_items [N_PHASES] = '{60, 50, 45, 70, 35, 45, 15};
    bit ph_big   [N_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    stable_counting_sort_by_key u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_key            (i_key),
        .i_last           (i_last),
        .strobe           (strobe),
        .o_item_index     (o_item_index),
        .o_bucket         (o_bucket),
        .o_bucket_start   (o_bucket_start),
        .o_rank_in_bucket (o_rank_in_bucket),
        .o_error          (o_error),
        .o_last_out       (o_last_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_sorted_slot mk_slot(int idx, int b, int s, int r, int e, int f);
        t_sorted_slot slot;
        slot.item_index   = FIELD_W'(idx);
        slot.bucket       = KEY_W'(b);
        slot.bucket_start = FIELD_W'(s);
        slot.rank         = FIELD_W'(r);
        slot.error        = e[0];
        slot.last_out     = f[0];
        return slot;
    endfunction

    function automatic t_row mk_row(t_row_kind kind, int k, int l, int cfg, bit typed,
                                    t_sorted_slot want);
        t_row row;
        row.kind  = kind;
        row.key   = KEY_W'(k);
        row.last  = l[0];
        row.cfg   = CFG_W'(cfg);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Takes one key beat; on the last beat of a batch it builds the bucket-grouped run.
    task automatic take_key(logic [KEY_W-1:0] k, logic l, bit keep);
        int unsigned  lim;
        int unsigned  offs;
        int unsigned  rank;
        t_sorted_slot run [$];
        lim = (bucket_limit > MAX_BUCKETS) ? MAX_BUCKETS : bucket_limit;
        if (k < lim && n_loaded < MAX_ITEMS) begin
            slot_key[n_loaded] = k;
            bucket_tally[k]++;
            n_loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!l) return;
        if (n_loaded == 0) begin
            run.push_back(mk_slot(0, 0, 0, 0, 1, 1));
        end else begin
            offs = 0;
            for (int b = 0; b < MAX_BUCKETS; b++) begin
                rank = 0;
                for (int i = 0; i < n_loaded; i++) begin
                    if (slot_key[i] == b) begin
                        run.push_back(mk_slot(i, b, offs, rank, 0, 0));
                        rank++;
                    end
                end
                offs += bucket_tally[b];
            end
            run[run.size() - 1].error    = dropped;
            run[run.size() - 1].last_out = 1'b1;
        end
        if (keep) begin
            foreach (run[j]) sorted_q.push_back(run[j]);
        end
        foreach (bucket_tally[b]) bucket_tally[b] = '0;
        n_loaded = 0;
        dropped  = 1'b0;
    endtask

    // Monitor: sampled at the edge, so it sees the values that the edge accepts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bucket_tally[b]) bucket_tally[b] = '0;
            n_loaded     = 0;
            dropped      = 1'b0;
            bucket_limit = scsk_pkg::BUCKET_COUNT_RESET;
        end else begin
            if (i_cfg_we) bucket_limit = i_cfg_wdata;
            if (start && !busy) begin
                if (tag_typed) sorted_q.push_back(tag_want);
                take_key(i_key, i_last, !tag_typed);
            end
            if (strobe) begin
                if (sorted_q.size() == 0) begin
                    $error("result beat with no expectation: index %0d bucket %0d",
                           o_item_index, o_bucket);
                    mismatches++;
                end else begin
                    got_want = sorted_q.pop_front();
                    check_field("item_index", 8'(got_want.item_index), 8'(o_item_index));
                    check_field("bucket", 8'(got_want.bucket), 8'(o_bucket));
                    check_field("bucket_start", 8'(got_want.bucket_start),
                                8'(o_bucket_start));
                    check_field("rank_in_bucket", 8'(got_want.rank), 8'(o_rank_in_bucket));
                    check_field("error", 8'(got_want.error), 8'(o_error));
                    check_field("last_out", 8'(got_want.last_out), 8'(o_last_out));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_beat(logic [KEY_W-1:0] k, logic l, bit typed, t_sorted_slot want);
        start     <= 1'b1;
        i_key     <= k;
        i_last    <= l;
        tag_typed <= typed;
        tag_want  <= want;
        do @(posedge i_clk); while (busy);
    endtask

    // Waits out every expected result, then lets the block finish clearing.
    task automatic drain_and_settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_limit    = (v > MAX_BUCKETS) ? MAX_BUCKETS : int'(v);
    endtask

    // Well-formed batches keep keys inside the live bucket range with the odd stray key.
    task automatic send_batch(int n, int idle_pct, bit tidy);
        logic [KEY_W-1:0] k;
        for (int j = 0; j < n; j++) begin
            if (tidy && cur_limit > 0 && $urandom_range(0, 19) != 0)
                k = KEY_W'($urandom_range(0, cur_limit - 1));
            else
                k = KEY_W'($urandom_range(0, 15));
            send_beat(k, j == n - 1, 1'b0, '0);
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int  sent;
        int  n;
        bit  big_pending;
        t_row row;

        directed_rows.push_back(mk_row(ROW_BEAT, 15, 1, 0, 1'b1, mk_slot(0, 0, 0, 0, 1, 1)));
        directed_rows.push_back(mk_row(ROW_BEAT, 0, 1, 0, 1'b1, mk_slot(0, 0, 0, 0, 0, 1)));
        directed_rows.push_back(mk_row(ROW_BEAT, 7, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 3, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 7, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 8, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 3, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 16, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 15, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 15, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 5, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 0, 1, 0, 1'b1, mk_slot(0, 0, 0, 0, 1, 1)));
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 31, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 15, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 10, 0, 0, 1'b0, '0));
        // The limit drops under a key already stored; that item must still come out.
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 4, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 10, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 2, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 1, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_CFG, 0, 0, 17, 1'b0, '0));
        directed_rows.push_back(mk_row(ROW_BEAT, 14, 1, 0, 1'b1, mk_slot(0, 14, 0, 0, 0, 1)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                drain_and_settle();
                write_bucket_count(row.cfg);
            end else begin
                send_beat(row.key, row.last, row.typed, row.want);
            end
        end

        // Phases with a full batch overrun the store to reach the store-full drop.
        for (int p = 0; p < N_PHASES; p++) begin
            drain_and_settle();
            write_bucket_count(CFG_W'(ph_cfg[p]));
            sent        = 0;
            big_pending = ph_big[p];
            while (sent < ph_items[p]) begin
                if (big_pending) begin
                    n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                    big_pending = 1'b0;
                    send_batch(n, ph_idle[p], 1'b1);
                end else if ($urandom_range(0, 9) < 8) begin
                    n = $urandom_range(1, 12);
                    send_batch(n, ph_idle[p], 1'b1);
                end else begin
                    n = $urandom_range(1, 6);
                    send_batch(n, ph_idle[p], 1'b0);
                end
                sent += n;
            end
        end

        drain_and_settle();
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/scsk_pkg.sv
src/scsk_ram.sv
src/scsk_ctrl.sv
src/scsk_dp.sv
src/stable_counting_sort_by_key.sv
dv/tb_stable_counting_sort_by_key.sv
